[hdl/mrpt_pkg.sv]
`default_nettype none

package mrpt_pkg;

   localparam int CANDIDATE_BITS = 63;
   localparam int RAW_BITS       = 31;
   localparam int RAW_CNT_BITS   = $clog2(RAW_BITS + 1);
   localparam int ROUND_BITS     = $clog2(CANDIDATE_BITS + 1);

   typedef logic [CANDIDATE_BITS-1:0] word_type;
   typedef logic [CANDIDATE_BITS:0]   wide_type;
   typedef logic [RAW_BITS-1:0]       raw_type;
   typedef logic [ROUND_BITS-1:0]     count_type;

   localparam word_type WORD_ONE = word_type'(1);
   localparam word_type WORD_TWO = word_type'(2);

   typedef enum logic {
      OP_MUL,
      OP_MOD
   } mrpt_op_type;

   typedef struct packed {
      logic        start;
      mrpt_op_type op;
   } mrpt_unit_ctl_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLASSIFY,
      S_SPLIT,
      S_WIT,
      S_WIT_WAIT,
      S_EXP,
      S_EXP_MUL_WAIT,
      S_EXP_SQ_WAIT,
      S_CHECK,
      S_SQ,
      S_SQ_WAIT,
      S_DONE
   } mrpt_state_type;

   // t is below twice m: one conditional subtract brings it below m
   function automatic word_type mod_reduce(input wide_type t, input word_type m);
      wide_type mw;
      wide_type d;
      mw = {1'b0, m};
      d  = t - mw;
      if (t >= mw) begin
         return d[CANDIDATE_BITS-1:0];
      end
      return t[CANDIDATE_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

[hdl/mrpt_mulmod.sv]
`default_nettype none

module mrpt_mulmod
   import mrpt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mrpt_unit_ctl_type ctl,
   input  wire word_type          opnd_a,
   input  wire word_type          opnd_b,
   input  wire word_type          modulus,
   input  wire raw_type           raw,
   output logic                   done,
   output word_type               result
);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   mrpt_op_type               op_ff, op_in;
   word_type                  acc_ff, acc_in;
   word_type                  y_ff, y_in;
   word_type                  b_ff, b_in;
   word_type                  m_ff, m_in;
   raw_type                   raw_ff, raw_in;
   logic [RAW_CNT_BITS-1:0]   cnt_ff, cnt_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      acc_in  = acc_ff;
      y_in    = y_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      raw_in  = raw_ff;
      cnt_in  = cnt_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         acc_in  = '0;
         y_in    = opnd_a;
         b_in    = opnd_b;
         m_in    = modulus;
         raw_in  = raw;
         cnt_in  = RAW_CNT_BITS'(RAW_BITS);
      end else if (busy_ff) begin
         case (op_ff)
            OP_MUL: begin
               // shift-add product, multiplier bits taken lowest first
               if (b_ff == '0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  if (b_ff[0]) begin
                     acc_in = mod_reduce({1'b0, acc_ff} + {1'b0, y_ff}, m_ff);
                  end
                  y_in = mod_reduce({y_ff, 1'b0}, m_ff);
                  b_in = b_ff >> 1;
               end
            end
            OP_MOD: begin
               // restoring remainder, one raw bit per cycle from the top
               if (cnt_ff == '0) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
               end else begin
                  acc_in = mod_reduce({acc_ff, raw_ff[RAW_BITS-1]}, m_ff);
                  raw_in = raw_ff << 1;
                  cnt_in = cnt_ff - 1'b1;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      acc_ff <= acc_in;
      y_ff   <= y_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      raw_ff <= raw_in;
      cnt_ff <= cnt_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff)
      else $error("operation started while unit busy");

   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (acc_ff < m_ff))
      else $error("unit result not reduced below modulus");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("done without a running operation");

endmodule

`default_nettype wire

[hdl/miller_rabin_primality_test.sv]
// Two-round Miller-Rabin probable-prime test on a 63-bit candidate.
// Input channel req_*: candidate plus one raw random value per round; a
// transaction completes when req_valid is high and req_stall is low.
// Result channel rsp_*: one transaction per input, rsp_probably_prime is 1
// when both rounds pass or the candidate is two. The receiver may hold
// rsp_stall; the result stays in its output register and a new
// candidate can be taken meanwhile, but the next result waits until the
// previous one has gone.
// Rejected candidates (below 2, even other than 2) and the candidate two
// go from S_CLASSIFY straight to S_DONE, which raises rsp_valid once the
// output register is free. Otherwise each round reduces its raw random
// value modulo p-1 to form the witness a, then computes a^s mod p and up
// to r-1 squarings; every modular product runs in the single shift-add
// unit until the bits of its multiplier are used up, and the sequencer
// passes S_EXP once per exponent bit and S_SQ once per squaring. req_stall
// is high for the whole time; one candidate is processed at a time.
// Reset (synchronous, active high) drops any item in flight and any
// undelivered result.
`default_nettype none

module miller_rabin_primality_test
   import mrpt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire word_type req_candidate,
   input  wire raw_type  req_random_first,
   input  wire raw_type  req_random_second,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output logic          rsp_probably_prime
);

   mrpt_state_type    state_ff, state_in;
   word_type          p_ff, p_in;
   word_type          pm1_ff, pm1_in;
   word_type          s_ff, s_in;
   count_type         r_ff, r_in;
   count_type         j_ff, j_in;
   word_type          e_ff, e_in;
   word_type          res_ff, res_in;
   word_type          base_ff, base_in;
   raw_type           raw1_ff, raw1_in;
   raw_type           raw2_ff, raw2_in;
   logic              round_ff, round_in;
   logic              verdict_ff, verdict_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_prime_ff, rsp_prime_in;

   mrpt_unit_ctl_type unit_ctl;
   word_type          unit_a;
   word_type          unit_b;
   word_type          unit_m;
   raw_type           unit_raw;
   logic              unit_done;
   word_type          unit_result;

   mrpt_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .ctl     (unit_ctl),
      .opnd_a  (unit_a),
      .opnd_b  (unit_b),
      .modulus (unit_m),
      .raw     (unit_raw),
      .done    (unit_done),
      .result  (unit_result)
   );

   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      pm1_in       = pm1_ff;
      s_in         = s_ff;
      r_in         = r_ff;
      j_in         = j_ff;
      e_in         = e_ff;
      res_in       = res_ff;
      base_in      = base_ff;
      raw1_in      = raw1_ff;
      raw2_in      = raw2_ff;
      round_in     = round_ff;
      verdict_in   = verdict_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_prime_in = rsp_prime_ff;
      unit_ctl     = '{start: 1'b0, op: OP_MUL};
      unit_a       = res_ff;
      unit_b       = base_ff;
      unit_m       = p_ff;
      unit_raw     = round_ff ? raw2_ff : raw1_ff;
      req_stall    = (state_ff != S_IDLE);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               p_in     = req_candidate;
               raw1_in  = req_random_first;
               raw2_in  = req_random_second;
               state_in = S_CLASSIFY;
            end
         end
         S_CLASSIFY: begin
            pm1_in   = p_ff - 1'b1;
            s_in     = p_ff - 1'b1;
            r_in     = '0;
            round_in = 1'b0;
            if (p_ff < WORD_TWO || (p_ff != WORD_TWO && !p_ff[0])) begin
               verdict_in = 1'b0;
               state_in   = S_DONE;
            end else if (p_ff == WORD_TWO) begin
               verdict_in = 1'b1;
               state_in   = S_DONE;
            end else begin
               state_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            // strip factors of two from p-1
            if (s_ff[0]) begin
               state_in = S_WIT;
            end else begin
               s_in = s_ff >> 1;
               r_in = r_ff + 1'b1;
            end
         end
         S_WIT: begin
            unit_ctl = '{start: 1'b1, op: OP_MOD};
            unit_m   = pm1_ff;
            state_in = S_WIT_WAIT;
         end
         S_WIT_WAIT: begin
            unit_m = pm1_ff;
            if (unit_done) begin
               base_in  = unit_result + 1'b1;
               res_in   = WORD_ONE;
               e_in     = s_ff;
               state_in = S_EXP;
            end
         end
         S_EXP: begin
            if (e_ff == '0) begin
               state_in = S_CHECK;
            end else if (e_ff[0]) begin
               unit_ctl = '{start: 1'b1, op: OP_MUL};
               state_in = S_EXP_MUL_WAIT;
            end else begin
               unit_ctl = '{start: 1'b1, op: OP_MUL};
               unit_a   = base_ff;
               state_in = S_EXP_SQ_WAIT;
            end
         end
         S_EXP_MUL_WAIT: begin
            if (unit_done) begin
               res_in   = unit_result;
               unit_ctl = '{start: 1'b1, op: OP_MUL};
               unit_a   = base_ff;
               state_in = S_EXP_SQ_WAIT;
            end
         end
         S_EXP_SQ_WAIT: begin
            unit_a = base_ff;
            if (unit_done) begin
               base_in  = unit_result;
               e_in     = e_ff >> 1;
               state_in = S_EXP;
            end
         end
         S_CHECK: begin
            j_in = count_type'(1);
            if (res_ff == WORD_ONE || res_ff == pm1_ff) begin
               if (round_ff) begin
                  verdict_in = 1'b1;
                  state_in   = S_DONE;
               end else begin
                  round_in = 1'b1;
                  state_in = S_WIT;
               end
            end else begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            unit_b = res_ff;
            if (j_ff >= r_ff) begin
               verdict_in = 1'b0;
               state_in   = S_DONE;
            end else begin
               unit_ctl = '{start: 1'b1, op: OP_MUL};
               state_in = S_SQ_WAIT;
            end
         end
         S_SQ_WAIT: begin
            unit_b = res_ff;
            if (unit_done) begin
               res_in = unit_result;
               j_in   = j_ff + 1'b1;
               if (unit_result == pm1_ff) begin
                  if (round_ff) begin
                     verdict_in = 1'b1;
                     state_in   = S_DONE;
                  end else begin
                     round_in = 1'b1;
                     state_in = S_WIT;
                  end
               end else if (unit_result == WORD_ONE) begin
                  verdict_in = 1'b0;
                  state_in   = S_DONE;
               end else begin
                  state_in = S_SQ;
               end
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = verdict_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p_ff         <= p_in;
      pm1_ff       <= pm1_in;
      s_ff         <= s_in;
      r_ff         <= r_in;
      j_ff         <= j_in;
      e_ff         <= e_in;
      res_ff       <= res_in;
      base_ff      <= base_in;
      raw1_ff      <= raw1_in;
      raw2_ff      <= raw2_in;
      round_ff     <= round_in;
      verdict_ff   <= verdict_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_probably_prime = rsp_prime_ff;

   a_split_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SPLIT) |-> (s_ff != '0))
      else $error("odd part of p-1 reached zero");

   a_split_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SPLIT) |-> (r_ff < count_type'(CANDIDATE_BITS)))
      else $error("power of two in p-1 out of range");

   a_check_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (res_ff < p_ff))
      else $error("power not reduced modulo candidate");

   a_witness_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WIT_WAIT && unit_done) |-> (unit_result < pm1_ff))
      else $error("witness remainder out of range");

endmodule

`default_nettype wire
